// ===== design/integer_factor_image_upscaler_core_assert.svh =====
// Assertion macros for the integer factor image upscaler core.
// Included by the top level; no other dependencies.
`ifndef INTEGER_FACTOR_IMAGE_UPSCALER_CORE_ASSERT_SVH
`define INTEGER_FACTOR_IMAGE_UPSCALER_CORE_ASSERT_SVH

// same-cycle implication
`define IFIU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IFIU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ifiu_pkg.sv =====
// Shared types, constants and reciprocal tables of the image upscaler.
// No dependencies.
package ifiu_pkg;

    localparam int COORD_W   = 11;
    localparam int DIM_W     = 9;
    localparam int SCALE_W   = 4;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int PIX_W     = NUM_CHAN * CHAN_W;
    localparam int CFG_IDX_W = 4;

    localparam int DIM_MIN   = 2;
    localparam int DIM_MAX   = 2 ** DIM_W - 1;
    localparam int DIM_RESET = 256;
    localparam int SCALE_MAX = 2 ** SCALE_W - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 4'd3;

    localparam logic OP_WRITE      = 1'b0;
    localparam logic OP_COMPUTE    = 1'b1;
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // axis divide: numerator up to 2*2047+15, divisor up to 2*15
    localparam int NUM_W       = 13;
    localparam int DEN_W       = 5;
    localparam int AXIS_K      = 13;
    localparam int RECIP_W     = 14;
    localparam int AXIS_PROD_W = NUM_W + RECIP_W;
    localparam int QUO_W       = 13;
    localparam int REM_W       = 5;
    localparam int QD_W        = QUO_W + DEN_W;

    // normalize by s*s: sum up to 225*255, quotient estimate up to 256
    localparam int WGT_W       = 8;
    localparam int ACC_W       = 16;
    localparam int NORM_K      = 16;
    localparam int NRECIP_W    = 17;
    localparam int NQ_W        = 9;
    localparam int NORM_PROD_W = NORM_K + NQ_W;
    localparam int NQD_W       = NQ_W + WGT_W;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [CHAN_W-1:0]  in_red;
        logic [CHAN_W-1:0]  in_green;
        logic [CHAN_W-1:0]  in_blue;
    } cmd_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } rgb_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     data;
    } cfg_word_t;

    typedef struct packed {
        logic [DIM_W-1:0]   base;
        logic [SCALE_W-1:0] frac;
    } axis_map_t;

    // ceil(2^13 / d)
    function automatic logic [RECIP_W-1:0] recip_axis(input logic [DEN_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            5'd1:    r = 14'd8192;
            5'd2:    r = 14'd4096;
            5'd3:    r = 14'd2731;
            5'd4:    r = 14'd2048;
            5'd5:    r = 14'd1639;
            5'd6:    r = 14'd1366;
            5'd7:    r = 14'd1171;
            5'd8:    r = 14'd1024;
            5'd9:    r = 14'd911;
            5'd10:   r = 14'd820;
            5'd11:   r = 14'd745;
            5'd12:   r = 14'd683;
            5'd13:   r = 14'd631;
            5'd14:   r = 14'd586;
            5'd15:   r = 14'd547;
            5'd16:   r = 14'd512;
            5'd17:   r = 14'd482;
            5'd18:   r = 14'd456;
            5'd19:   r = 14'd432;
            5'd20:   r = 14'd410;
            5'd21:   r = 14'd391;
            5'd22:   r = 14'd373;
            5'd23:   r = 14'd357;
            5'd24:   r = 14'd342;
            5'd25:   r = 14'd328;
            5'd26:   r = 14'd316;
            5'd27:   r = 14'd304;
            5'd28:   r = 14'd293;
            5'd29:   r = 14'd283;
            5'd30:   r = 14'd274;
            default: r = '0;
        endcase
        return r;
    endfunction

    // ceil(2^16 / s^2)
    function automatic logic [NRECIP_W-1:0] recip_sq(input logic [SCALE_W-1:0] s);
        logic [NRECIP_W-1:0] r;
        unique case (s)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd16384;
            4'd3:    r = 17'd7282;
            4'd4:    r = 17'd4096;
            4'd5:    r = 17'd2622;
            4'd6:    r = 17'd1821;
            4'd7:    r = 17'd1338;
            4'd8:    r = 17'd1024;
            4'd9:    r = 17'd810;
            4'd10:   r = 17'd656;
            4'd11:   r = 17'd542;
            4'd12:   r = 17'd456;
            4'd13:   r = 17'd388;
            4'd14:   r = 17'd335;
            4'd15:   r = 17'd292;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ifiu_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
// No dependencies; the word type is bound at instantiation.
interface ifiu_chan_if #(
    parameter type word_t = logic
) ();
    logic  valid;
    logic  ready;
    word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ===== design/ifiu_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module ifiu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/ifiu_axis_map.sv =====
// Maps one output coordinate to a source base index and fraction.
// Three register stages: reciprocal multiply, remainder fix-up, edge clamp.
// Depends on ifiu_pkg.
module ifiu_axis_map (
    input  logic                           clk,
    input  logic [ifiu_pkg::COORD_W-1:0]   coord,
    input  logic [ifiu_pkg::SCALE_W-1:0]   scale,
    input  logic [ifiu_pkg::DIM_W-1:0]     dim,
    input  logic                           bilinear,
    output ifiu_pkg::axis_map_t            map
);
    import ifiu_pkg::*;

    logic [NUM_W-1:0]       num;
    logic [DEN_W-1:0]       den;
    logic [AXIS_PROD_W-1:0] prod_reg, prod_next;
    logic [QUO_W-1:0]       q0;
    logic [QD_W-1:0]        qd;
    logic [QUO_W-1:0]       q_reg, q_next;
    logic [REM_W-1:0]       r_reg, r_next;
    axis_map_t              map_reg, map_next;

    // nearest: (2x + s) / 2s, bilinear: x / s
    always_comb
    begin
        if (bilinear)
        begin
            num = NUM_W'(coord);
            den = DEN_W'(scale);
        end
        else
        begin
            num = NUM_W'({coord, 1'b0}) + NUM_W'(scale);
            den = DEN_W'({scale, 1'b0});
        end
        prod_next = AXIS_PROD_W'(num) * AXIS_PROD_W'(recip_axis(den));
    end

    // estimate is exact or one too high
    always_comb
    begin
        q0 = prod_reg[AXIS_K +: QUO_W];
        qd = QD_W'(q0) * QD_W'(den);
        if (qd > QD_W'(num))
        begin
            q_next = q0 - QUO_W'(1);
            r_next = REM_W'(QD_W'(num) + QD_W'(den) - qd);
        end
        else
        begin
            q_next = q0;
            r_next = REM_W'(QD_W'(num) - qd);
        end
    end

    always_comb
    begin
        map_next.frac = SCALE_W'(r_reg);
        if (bilinear)
        begin
            if ((q_reg + QUO_W'(1)) >= QUO_W'(dim))
            begin
                map_next.base = dim - DIM_W'(2);
            end
            else
            begin
                map_next.base = DIM_W'(q_reg);
            end
        end
        else
        begin
            if (q_reg >= QUO_W'(dim))
            begin
                map_next.base = dim - DIM_W'(1);
            end
            else
            begin
                map_next.base = DIM_W'(q_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        map_reg  <= map_next;
    end

    assign map = map_reg;
endmodule

// ===== design/integer_factor_image_upscaler_core.sv =====
// Integer factor image upscaler: top level with frame memory and blend datapath.
// Depends on ifiu_pkg, ifiu_chan_if, ifiu_ram, ifiu_axis_map and the assert header.
//
// Channels: cmd (sink) takes pixel writes and compute requests, result (source)
// returns one RGB word per compute request, cfg (sink) writes the four
// registers and is always ready.
// A pixel write goes straight to memory and cmd stays ready for the next word.
// A compute request keeps cmd busy until its result is in the output register,
// so no new word is taken before the last result is loaded. The busy time
// is set by the single frame memory port (one source pixel read per cycle, four
// for bilinear) plus the axis divide and normalize stages.
// The result word is registered; cmd is ready again while it waits to be taken.
// If result is stalled and a second result is done, the block holds it in the
// final stage and cmd stays busy until the output register frees up.
// Reset sets the registers to width 256, height 256 (capped by the frame size),
// scale 1, nearest mode. The frame memory is not cleared and a source pixel
// must be written before it is read.
`include "integer_factor_image_upscaler_core_assert.svh"

module integer_factor_image_upscaler_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SCALE  = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    ifiu_chan_if.sink    cmd,
    ifiu_chan_if.source  result,
    ifiu_chan_if.sink    cfg
);
    import ifiu_pkg::*;

    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WIDTH_CAP  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int HEIGHT_CAP = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int SCALE_CAP  = (MAX_SCALE < SCALE_MAX) ? MAX_SCALE : SCALE_MAX;
    localparam int WIDTH_RST  = (WIDTH_CAP < DIM_RESET) ? WIDTH_CAP : DIM_RESET;
    localparam int HEIGHT_RST = (HEIGHT_CAP < DIM_RESET) ? HEIGHT_CAP : DIM_RESET;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_FIX   = 4'd2;
    localparam logic [3:0] ST_CLAMP = 4'd3;
    localparam logic [3:0] ST_WGT   = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_DMUL  = 4'd7;
    localparam logic [3:0] ST_DFIX  = 4'd8;

    localparam logic [1:0] RD_LAST_NEAR = 2'd0;
    localparam logic [1:0] RD_LAST_BIL  = 2'd3;

    // config
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               filter_mode_reg;
    logic [DIM_W-1:0]   width_sat, height_sat;
    logic [SCALE_W-1:0] scale_raw, scale_sat;
    logic               cfg_fire;

    // control
    logic [3:0] state_reg, state_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic [1:0] rd_last;
    logic       rd_vld_reg;
    logic [1:0] rd_sel_reg;
    logic       cmd_fire;
    logic       out_valid_reg;
    logic       out_free;
    logic       out_load;

    // datapath
    logic [COORD_W-1:0]     x_reg, y_reg;
    axis_map_t              map_x, map_y;
    logic [SCALE_W-1:0]     fx, fy, gx, gy;
    logic [WGT_W-1:0]       w_reg [4];
    logic [WGT_W-1:0]       w_next [4];
    logic [SCALE_W-1:0]     div_s_reg, div_s_next;
    logic [WGT_W-1:0]       div_sq_reg;
    logic [ADDR_W-1:0]      base_addr_reg, base_addr_next;
    logic [ADDR_W-1:0]      rd_off;
    logic [ACC_W-1:0]       acc_reg [NUM_CHAN];
    logic [ACC_W-1:0]       acc_next [NUM_CHAN];
    logic [NORM_PROD_W-1:0] dprod_reg [NUM_CHAN];
    logic [NQ_W-1:0]        nq0 [NUM_CHAN];
    logic [NQD_W-1:0]       nqd [NUM_CHAN];
    logic [CHAN_W-1:0]      res [NUM_CHAN];
    rgb_word_t              out_word_reg;

    // frame memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr, wr_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        if (cfg.word.data < DIM_W'(DIM_MIN))
        begin
            width_sat  = DIM_W'(DIM_MIN);
        end
        else if (DIM_W'(WIDTH_CAP) < cfg.word.data)
        begin
            width_sat  = DIM_W'(WIDTH_CAP);
        end
        else
        begin
            width_sat  = cfg.word.data;
        end

        if (cfg.word.data < DIM_W'(DIM_MIN))
        begin
            height_sat = DIM_W'(DIM_MIN);
        end
        else if (DIM_W'(HEIGHT_CAP) < cfg.word.data)
        begin
            height_sat = DIM_W'(HEIGHT_CAP);
        end
        else
        begin
            height_sat = cfg.word.data;
        end

        scale_raw = cfg.word.data[SCALE_W-1:0];
        if (scale_raw == '0)
        begin
            scale_sat = SCALE_W'(1);
        end
        else if (SCALE_W'(SCALE_CAP) < scale_raw)
        begin
            scale_sat = SCALE_W'(SCALE_CAP);
        end
        else
        begin
            scale_sat = scale_raw;
        end
    end

    // effective (saturated) values are stored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= DIM_W'(WIDTH_RST);
            height_reg      <= DIM_W'(HEIGHT_RST);
            scale_reg       <= SCALE_W'(1);
            filter_mode_reg <= MODE_NEAREST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.word.index)
                CFG_SRC_WIDTH:    width_reg       <= width_sat;
                CFG_SRC_HEIGHT:   height_reg      <= height_sat;
                CFG_SCALE_FACTOR: scale_reg       <= scale_sat;
                CFG_FILTER_MODE:  filter_mode_reg <= cfg.word.data[0];
                default:          ;
            endcase
        end
    end

    // pixel writes go straight to memory
    assign ram_we = cmd_fire && (cmd.word.operation == OP_WRITE)
                    && (cmd.word.coord_x < COORD_W'(width_reg))
                    && (cmd.word.coord_y < COORD_W'(height_reg));
    assign wr_addr = ADDR_W'(cmd.word.coord_y) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(cmd.word.coord_x);
    assign ram_wdata = {cmd.word.in_red, cmd.word.in_green, cmd.word.in_blue};

    always_comb
    begin
        unique case (rd_cnt_reg)
            2'd0:    rd_off = '0;
            2'd1:    rd_off = ADDR_W'(1);
            2'd2:    rd_off = ADDR_W'(MAX_WIDTH);
            default: rd_off = ADDR_W'(MAX_WIDTH) + ADDR_W'(1);
        endcase
        ram_addr = ram_we ? wr_addr : base_addr_reg + rd_off;
    end

    ifiu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ifiu_axis_map u_map_x (
        .clk      (clk),
        .coord    (x_reg),
        .scale    (scale_reg),
        .dim      (width_reg),
        .bilinear (filter_mode_reg),
        .map      (map_x)
    );

    ifiu_axis_map u_map_y (
        .clk      (clk),
        .coord    (y_reg),
        .scale    (scale_reg),
        .dim      (height_reg),
        .bilinear (filter_mode_reg),
        .map      (map_y)
    );

    // tap weights; nearest uses one tap of weight 1 and a unit divisor
    always_comb
    begin
        fx = map_x.frac;
        fy = map_y.frac;
        gx = scale_reg - fx;
        gy = scale_reg - fy;
        if (filter_mode_reg == MODE_BILINEAR)
        begin
            w_next[0]  = WGT_W'(gx) * WGT_W'(gy);
            w_next[1]  = WGT_W'(fx) * WGT_W'(gy);
            w_next[2]  = WGT_W'(gx) * WGT_W'(fy);
            w_next[3]  = WGT_W'(fx) * WGT_W'(fy);
            div_s_next = scale_reg;
        end
        else
        begin
            w_next[0]  = WGT_W'(1);
            w_next[1]  = '0;
            w_next[2]  = '0;
            w_next[3]  = '0;
            div_s_next = SCALE_W'(1);
        end
        base_addr_next = ADDR_W'(map_y.base) * ADDR_W'(MAX_WIDTH) + ADDR_W'(map_x.base);
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            acc_next[k] = acc_reg[k] + ACC_W'(w_reg[rd_sel_reg])
                          * ACC_W'(ram_rdata[(NUM_CHAN - 1 - k) * CHAN_W +: CHAN_W]);
            nq0[k] = dprod_reg[k][NORM_K +: NQ_W];
            nqd[k] = NQD_W'(nq0[k]) * NQD_W'(div_sq_reg);
            if (nqd[k] > NQD_W'(acc_reg[k]))
            begin
                res[k] = CHAN_W'(nq0[k] - NQ_W'(1));
            end
            else
            begin
                res[k] = CHAN_W'(nq0[k]);
            end
        end
    end

    assign rd_last  = (filter_mode_reg == MODE_BILINEAR) ? RD_LAST_BIL : RD_LAST_NEAR;
    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (state_reg == ST_DFIX) && out_free;

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.word.operation == OP_COMPUTE))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_FIX;
            ST_FIX:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_WGT;
            ST_WGT:
            begin
                state_next  = ST_READ;
                rd_cnt_next = '0;
            end
            ST_READ:
            begin
                if (rd_cnt_reg == rd_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 2'd1;
                end
            end
            ST_DRAIN: state_next = ST_DMUL;
            ST_DMUL:  state_next = ST_DFIX;
            ST_DFIX:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            rd_vld_reg <= (state_reg == ST_READ);
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            x_reg <= cmd.word.coord_x;
            y_reg <= cmd.word.coord_y;
        end
        if (state_reg == ST_WGT)
        begin
            w_reg         <= w_next;
            div_s_reg     <= div_s_next;
            div_sq_reg    <= WGT_W'(div_s_next) * WGT_W'(div_s_next);
            base_addr_reg <= base_addr_next;
        end
        rd_sel_reg <= rd_cnt_reg;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (state_reg == ST_WGT)
            begin
                acc_reg[k] <= '0;
            end
            else if (rd_vld_reg)
            begin
                acc_reg[k] <= acc_next[k];
            end
            if (state_reg == ST_DMUL)
            begin
                dprod_reg[k] <= NORM_PROD_W'(acc_reg[k])
                                * NORM_PROD_W'(recip_sq(div_s_reg));
            end
        end
        if (out_load)
        begin
            out_word_reg.out_red   <= res[0];
            out_word_reg.out_green <= res[1];
            out_word_reg.out_blue  <= res[2];
        end
    end

    assign result.valid = out_valid_reg;
    assign result.word  = out_word_reg;

    `IFIU_ASSERT_IMP(a_rd_window, clk, rst_n, rd_vld_reg, (state_reg == ST_READ) || (state_reg == ST_DRAIN), "read data arrived outside the fetch window")
    `IFIU_ASSERT_IMP(a_near_one_read, clk, rst_n, (state_reg == ST_READ) && (filter_mode_reg == MODE_NEAREST), rd_cnt_reg == RD_LAST_NEAR, "nearest mode issued more than one read")
    `IFIU_ASSERT_NXT(a_result_load, clk, rst_n, (state_reg == ST_DFIX) && out_free, out_valid_reg && (state_reg == ST_IDLE), "finished result not loaded")
    `IFIU_ASSERT_IMP(a_result_source, clk, rst_n, out_valid_reg && !$past(out_valid_reg), $past(state_reg) == ST_DFIX, "result appeared without a finished compute")
    `IFIU_ASSERT_IMP(a_port_free, clk, rst_n, ram_we, !rd_vld_reg && (state_reg == ST_IDLE), "memory write during a fetch")
endmodule

// ===== sim/tb_integer_factor_image_upscaler_core.sv =====
// Testbench for integer_factor_image_upscaler_core: writes source pixels, requests
// nearest and bilinear output pixels under many settings, checks every RGB word.
// Depends on ifiu_pkg, ifiu_chan_if and the upscaler RTL.
module tb_integer_factor_image_upscaler_core;
    import ifiu_pkg::*;

    localparam int FRAME_W     = 256;
    localparam int FRAME_H     = 256;
    localparam int FRAME_AW    = $clog2(FRAME_W * FRAME_H);
    localparam int SCALE_LIMIT = 8;
    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYC  = 24;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [SCALE_W-1:0] scale;
        logic               mode;
    } upscale_cfg_t;

    localparam upscale_cfg_t RESET_CFG = '{width: 9'd256, height: 9'd256, scale: 4'd1,
                                          mode: MODE_NEAREST};

    logic clk = 1'b0;
    logic rst_n;

    ifiu_chan_if #(.word_t(cmd_word_t)) cmd_ch ();
    ifiu_chan_if #(.word_t(rgb_word_t)) rgb_ch ();
    ifiu_chan_if #(.word_t(cfg_word_t)) cfg_ch ();

    integer_factor_image_upscaler_core #(
        .MAX_WIDTH  (FRAME_W),
        .MAX_HEIGHT (FRAME_H),
        .MAX_SCALE  (SCALE_LIMIT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (rgb_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    // predictor state
    upscale_cfg_t     pred_cfg;
    logic [PIX_W-1:0] src_frame [FRAME_W*FRAME_H];
    rgb_word_t        expected_rgb [$];

    // stimulus state
    upscale_cfg_t     stim_cfg;
    bit               stim_written [FRAME_W*FRAME_H];
    cmd_word_t        pending_cmds [$];
    int unsigned      stim_words;

    int               mismatches;
    int               cmd_gap, cmd_burst, ready_stall, ready_burst, quiet_cycles;
    string            chan_name [NUM_CHAN] = '{"blue", "green", "red"};

    function automatic logic [FRAME_AW-1:0] frame_idx(int unsigned x, int unsigned y);
        return FRAME_AW'(y * FRAME_W + x);
    endfunction

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned limit);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_scale(logic [SCALE_W-1:0] v);
        if (v == 0) return 1;
        if (v > SCALE_LIMIT) return SCALE_LIMIT;
        return 32'(v);
    endfunction

    // round(o / s), clamped to the last index
    function automatic int unsigned near_src(int unsigned o, int unsigned s, int unsigned dim);
        int unsigned v;
        v = (2 * o + s) / (2 * s);
        return (v >= dim) ? dim - 1 : v;
    endfunction

    function automatic int unsigned blend_base(int unsigned o, int unsigned s, int unsigned dim);
        int unsigned v;
        v = o / s;
        return (v + 1 >= dim) ? dim - 2 : v;
    endfunction

    function automatic void apply_reg(inout upscale_cfg_t c, input cfg_word_t w);
        unique case (w.index)
            CFG_SRC_WIDTH:    c.width  = w.data;
            CFG_SRC_HEIGHT:   c.height = w.data;
            CFG_SCALE_FACTOR: c.scale  = w.data[SCALE_W-1:0];
            CFG_FILTER_MODE:  c.mode   = w.data[0];
            default:          ;
        endcase
    endfunction

    function automatic rgb_word_t scaled_pixel(cmd_word_t c);
        int unsigned      w, h, s, bx, by, fx, fy, gx, gy, acc;
        logic [PIX_W-1:0] p00, p10, p01, p11;
        rgb_word_t        px;
        w = eff_dim(pred_cfg.width, FRAME_W);
        h = eff_dim(pred_cfg.height, FRAME_H);
        s = eff_scale(pred_cfg.scale);
        if (pred_cfg.mode == MODE_NEAREST)
            return src_frame[frame_idx(near_src(32'(c.coord_x), s, w),
                                       near_src(32'(c.coord_y), s, h))];
        bx = blend_base(32'(c.coord_x), s, w);
        by = blend_base(32'(c.coord_y), s, h);
        fx = 32'(c.coord_x) % s;
        fy = 32'(c.coord_y) % s;
        gx = s - fx;
        gy = s - fy;
        p00 = src_frame[frame_idx(bx, by)];
        p10 = src_frame[frame_idx(bx + 1, by)];
        p01 = src_frame[frame_idx(bx, by + 1)];
        p11 = src_frame[frame_idx(bx + 1, by + 1)];
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            acc = gx * gy * p00[CHAN_W*k +: CHAN_W] + fx * gy * p10[CHAN_W*k +: CHAN_W]
                + gx * fy * p01[CHAN_W*k +: CHAN_W] + fx * fy * p11[CHAN_W*k +: CHAN_W];
            px[CHAN_W*k +: CHAN_W] = CHAN_W'(acc / (s * s));
        end
        return px;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int draw_gap(inout int burst);
        int roll;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            burst = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return DIM_W'($urandom_range(2, 12));
        if (roll < 70) return DIM_W'(DIM_MIN);
        if (roll < 80) return DIM_W'(FRAME_W);
        if (roll < 85) return DIM_W'($urandom_range(0, 1));
        if (roll < 92) return DIM_W'($urandom_range(FRAME_W + 1, DIM_MAX));
        return DIM_W'($urandom_range(13, FRAME_W));
    endfunction

    function automatic logic [DIM_W-1:0] pick_scale();
        logic [DIM_W-SCALE_W-1:0] junk;
        logic [SCALE_W-1:0]       s;
        int                       roll;
        roll = $urandom_range(0, 99);
        junk = $urandom_range(0, 1) ? (DIM_W-SCALE_W)'($urandom) : '0;
        if (roll < 10)      s = '0;
        else if (roll < 18) s = SCALE_W'($urandom_range(SCALE_LIMIT + 1, SCALE_MAX));
        else if (roll < 30) s = SCALE_W'(SCALE_LIMIT);
        else if (roll < 40) s = SCALE_W'(1);
        else                s = SCALE_W'($urandom_range(1, SCALE_LIMIT));
        return {junk, s};
    endfunction

    // driver: feeds cmd words, keeps the source frame copy and queues predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.word  <= '0;
            cmd_gap = 0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_ch.valid)
            begin
                if (cmd_ch.word.operation == OP_COMPUTE)
                    expected_rgb.push_back(scaled_pixel(cmd_ch.word));
                else if (cmd_ch.word.coord_x < eff_dim(pred_cfg.width, FRAME_W) &&
                         cmd_ch.word.coord_y < eff_dim(pred_cfg.height, FRAME_H))
                    src_frame[frame_idx(32'(cmd_ch.word.coord_x), 32'(cmd_ch.word.coord_y))] =
                        {cmd_ch.word.in_red, cmd_ch.word.in_green, cmd_ch.word.in_blue};
            end
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd_ch.word  <= pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_gap = draw_gap(cmd_burst);
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pred_cfg = RESET_CFG;
        else if (cfg_ch.valid && cfg_ch.ready)
            apply_reg(pred_cfg, cfg_ch.word);
    end

    // monitor: random back-pressure on result, field compare against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_results
        rgb_word_t want;
        if (!rst_n)
        begin
            rgb_ch.ready <= 1'b0;
            ready_stall = 0;
        end
        else
        begin
            if (rgb_ch.valid && rgb_ch.ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, rgb_ch.word);
                    mismatches++;
                end
                else
                begin
                    want = expected_rgb.pop_front();
                    for (int k = 0; k < NUM_CHAN; k++)
                        if (rgb_ch.word[CHAN_W*k +: CHAN_W] !== want[CHAN_W*k +: CHAN_W])
                        begin
                            $display("%0t: %s expected %0d, got %0d", $time, chan_name[k],
                                     want[CHAN_W*k +: CHAN_W], rgb_ch.word[CHAN_W*k +: CHAN_W]);
                            mismatches++;
                        end
                end
            end
            if (ready_stall == 0 && $urandom_range(0, 3) == 0)
                ready_stall = draw_gap(ready_burst);
            if (ready_stall > 0)
            begin
                ready_stall--;
                rgb_ch.ready <= 1'b0;
            end
            else
            begin
                rgb_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rgb_ch.valid && rgb_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic queue_write(int unsigned x, int unsigned y, logic [PIX_W-1:0] rgb);
        cmd_word_t item;
        item.operation = OP_WRITE;
        item.coord_x   = COORD_W'(x);
        item.coord_y   = COORD_W'(y);
        {item.in_red, item.in_green, item.in_blue} = rgb;
        pending_cmds.push_back(item);
        stim_words++;
        if (x < eff_dim(stim_cfg.width, FRAME_W) && y < eff_dim(stim_cfg.height, FRAME_H))
            stim_written[frame_idx(x, y)] = 1'b1;
    endtask

    // queues a compute request, after writes for any source pixels it will read that are not yet written
    task automatic queue_compute(int unsigned x, int unsigned y);
        int unsigned w, h, s, c0, r0, span;
        cmd_word_t   item;
        w = eff_dim(stim_cfg.width, FRAME_W);
        h = eff_dim(stim_cfg.height, FRAME_H);
        s = eff_scale(stim_cfg.scale);
        if (stim_cfg.mode == MODE_NEAREST)
        begin
            c0   = near_src(x, s, w);
            r0   = near_src(y, s, h);
            span = 0;
        end
        else
        begin
            c0   = blend_base(x, s, w);
            r0   = blend_base(y, s, h);
            span = 1;
        end
        for (int dy = 0; dy <= span; dy++)
            for (int dx = 0; dx <= span; dx++)
                if (!stim_written[frame_idx(c0 + dx, r0 + dy)])
                    queue_write(c0 + dx, r0 + dy, PIX_W'($urandom));
        item.operation = OP_COMPUTE;
        item.coord_x   = COORD_W'(x);
        item.coord_y   = COORD_W'(y);
        {item.in_red, item.in_green, item.in_blue} = PIX_W'($urandom);
        pending_cmds.push_back(item);
        stim_words++;
    endtask

    task automatic settle();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_rgb.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        cfg_word_t w;
        w.index = idx;
        w.data  = data;
        @(posedge clk);
        cfg_ch.word  <= w;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        apply_reg(stim_cfg, w);
    endtask

    task automatic new_setting(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               logic [DIM_W-1:0] s, logic [DIM_W-1:0] m);
        settle();
        set_reg(CFG_SRC_WIDTH, w);
        set_reg(CFG_SRC_HEIGHT, h);
        set_reg(CFG_SCALE_FACTOR, s);
        set_reg(CFG_FILTER_MODE, m);
        if ($urandom_range(0, 2) == 0)
            set_reg(CFG_IDX_W'($urandom_range(CFG_FILTER_MODE + 1, 2 ** CFG_IDX_W - 1)),
                    DIM_W'($urandom));
    endtask

    task automatic run_phase(int unsigned n);
        int unsigned w, h, xspan, yspan, start;
        int          roll;
        start = stim_words;
        w     = eff_dim(stim_cfg.width, FRAME_W);
        h     = eff_dim(stim_cfg.height, FRAME_H);
        xspan = w * eff_scale(stim_cfg.scale);
        yspan = h * eff_scale(stim_cfg.scale);
        if (xspan > 2 ** COORD_W) xspan = 2 ** COORD_W;
        if (yspan > 2 ** COORD_W) yspan = 2 ** COORD_W;
        while (stim_words - start < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 14)
                queue_compute($urandom_range(0, 2 ** COORD_W - 1),
                              $urandom_range(0, 2 ** COORD_W - 1));
            else if (roll < 70)
                queue_compute($urandom_range(0, xspan - 1), $urandom_range(0, yspan - 1));
            else if (roll < 90)
                queue_write($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                            PIX_W'($urandom));
            else
                queue_write($urandom_range(0, 2 ** COORD_W - 1),
                            $urandom_range(0, 2 ** COORD_W - 1), PIX_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.word  = '0;
        rgb_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.word  = '0;
        stim_cfg     = RESET_CFG;
        stim_words   = 0;
        mismatches   = 0;
        cmd_burst    = 0;
        ready_burst  = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: corners, writes outside the frame, clamped request
        queue_write(0, 0, 24'hFFFFFF);
        queue_write(FRAME_W - 1, FRAME_H - 1, 24'h000000);
        queue_write(2 ** COORD_W - 1, 2 ** COORD_W - 1, PIX_W'($urandom));
        queue_write(FRAME_W, 5, PIX_W'($urandom));
        queue_write(5, FRAME_H, PIX_W'($urandom));
        queue_compute(0, 0);
        queue_compute(2 ** COORD_W - 1, 2 ** COORD_W - 1);
        queue_compute(FRAME_W - 1, 0);

        // smallest frame, largest scale, bilinear with edge step-back
        new_setting(DIM_W'(DIM_MIN), DIM_W'(DIM_MIN), DIM_W'(SCALE_LIMIT),
                    DIM_W'(MODE_BILINEAR));
        queue_write(1, 0, 24'h00FF00);
        queue_write(0, 1, 24'hFF0000);
        queue_write(1, 1, 24'h0000FF);
        queue_compute(0, 0);
        queue_compute(7, 7);
        queue_compute(15, 15);
        queue_compute(3, 12);
        queue_compute(2 ** COORD_W - 1, 2 ** COORD_W - 1);

        // nearest rounding and clamp at an odd scale
        new_setting(9'd4, 9'd3, 9'd3, DIM_W'(MODE_NEAREST));
        queue_compute(1, 0);
        queue_compute(2, 1);
        queue_compute(11, 8);
        queue_compute(2 ** COORD_W - 1, 0);

        while (stim_words < ITEM_TARGET)
        begin
            new_setting(pick_dim(), pick_dim(), pick_scale(),
                        {8'($urandom_range(0, 1) ? $urandom : 0), 1'($urandom)});
            run_phase($urandom_range(60, 180));
        end
        settle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/ifiu_pkg.sv
design/ifiu_chan_if.sv
design/ifiu_ram.sv
design/ifiu_axis_map.sv
design/integer_factor_image_upscaler_core.sv
sim/tb_integer_factor_image_upscaler_core.sv
